### rtl/mcc_pkg.sv
// Package for the multichannel point convolution block.
// Shared constants, types and the front-to-back command struct; no dependencies.
package mcc_pkg;

	localparam int MaxRows     = 64;
	localparam int MaxCols     = 64;
	localparam int MaxChannels = 4;
	localparam int MaxKernel   = 7;

	localparam int SumW = 40;
	localparam int CfgW = 7;
	localparam int IdxW = 3;

	localparam logic [1:0] ACT_WEIGHT  = 2'd0;
	localparam logic [1:0] ACT_PIXEL   = 2'd1;
	localparam logic [1:0] ACT_COMPUTE = 2'd2;

	localparam logic [IdxW-1:0] REG_KERNEL  = 3'd0;
	localparam logic [IdxW-1:0] REG_STRIDE  = 3'd1;
	localparam logic [IdxW-1:0] REG_PAD     = 3'd2;
	localparam logic [IdxW-1:0] REG_ROWS    = 3'd3;
	localparam logic [IdxW-1:0] REG_COLS    = 3'd4;
	localparam logic [IdxW-1:0] REG_CHANNEL = 3'd5;

	// One store write or compute job handed from the front to the back
	typedef struct packed {
		logic [1:0]  act;
		logic        in_range;
		logic [1:0]  channel;
		logic [5:0]  row_pos;
		logic [5:0]  col_pos;
		logic [15:0] data;
	} job_t;

endpackage

### rtl/mcc_front.sv
// Front end: accepts items, drops out-of-range writes and unused actions,
// checks the output position and queues jobs for the back end. Depends on mcc_pkg.
module mcc_front #(
	parameter int MAX_ROWS     = mcc_pkg::MaxRows,
	parameter int MAX_COLS     = mcc_pkg::MaxCols,
	parameter int MAX_CHANNELS = mcc_pkg::MaxChannels,
	parameter int MAX_KERNEL   = mcc_pkg::MaxKernel,
	parameter int QDEPTH       = 2
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  logic [1:0]          action,
	input  logic [1:0]          channel,
	input  logic [5:0]          row_pos,
	input  logic [5:0]          col_pos,
	input  logic signed [15:0]  weight,
	input  logic signed [15:0]  pixel,
	input  logic [2:0]          k_eff,
	input  logic [2:0]          s_eff,
	input  logic [2:0]          pad,
	input  logic [10:0]         nr_eff,
	input  logic [10:0]         nc_eff,
	// job queue read side
	output logic                job_valid,
	output mcc_pkg::job_t       job,
	input  logic                job_take
);
	localparam int QPW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCW = $clog2(QDEPTH+1);

	mcc_pkg::job_t   q_q [QDEPTH];
	logic [QPW-1:0]  wp_q, rp_q;
	logic [QCW-1:0]  cnt_q;
	logic            acc_in, is_cmp, wr_ok, px_ok, wr_go, px_go, enq, deq;
	logic [12:0]     span_r, span_c, lim_r, lim_c, pr, pc;
	logic            in_r, in_c;

	assign full   = (cnt_q == QCW'(QDEPTH));
	assign acc_in = push && !full;
	assign is_cmp = (action == mcc_pkg::ACT_COMPUTE);
	assign wr_ok  = ({30'd0, channel} < MAX_CHANNELS) && ({26'd0, row_pos} < MAX_KERNEL)
		&& ({26'd0, col_pos} < MAX_KERNEL);
	assign px_ok  = ({30'd0, channel} < MAX_CHANNELS) && ({26'd0, row_pos} < MAX_ROWS)
		&& ({26'd0, col_pos} < MAX_COLS);
	assign wr_go  = (action == mcc_pkg::ACT_WEIGHT) && wr_ok;
	assign px_go  = (action == mcc_pkg::ACT_PIXEL) && px_ok;

	// position in range when pos*s + k <= img + 2*pad (equivalent to pos < out size)
	assign span_r = 13'(nr_eff) + 13'({pad, 1'b0});
	assign span_c = 13'(nc_eff) + 13'({pad, 1'b0});
	assign pr     = 13'(row_pos) * 13'(s_eff) + 13'(k_eff);
	assign pc     = 13'(col_pos) * 13'(s_eff) + 13'(k_eff);
	assign lim_r  = span_r;
	assign lim_c  = span_c;
	assign in_r   = pr <= lim_r;
	assign in_c   = pc <= lim_c;

	// writes travel through the queue so they stay in order with compute jobs
	assign enq       = acc_in && (is_cmp || wr_go || px_go);
	assign job_valid = (cnt_q != '0);
	assign job       = q_q[rp_q];
	assign deq       = job_take && job_valid;

	// job queue payload
	always_ff @(posedge clk) begin
		if (enq) begin
			q_q[wp_q] <= '{act: action, in_range: in_r && in_c, channel: channel,
				row_pos: row_pos, col_pos: col_pos,
				data: (action == mcc_pkg::ACT_WEIGHT) ? weight : pixel};
		end
	end

	// advance queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (enq) wp_q <= (wp_q == QPW'(QDEPTH-1)) ? '0 : wp_q + 1'b1;
			if (deq) rp_q <= (rp_q == QPW'(QDEPTH-1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + QCW'(enq) - QCW'(deq);
		end
	end
endmodule

### rtl/mcc_back.sv
// Back end: writes both stores, walks channels and kernel taps of one job,
// multiplies and accumulates, and holds the result. Depends on mcc_pkg.
module mcc_back #(
	parameter int MAX_ROWS     = mcc_pkg::MaxRows,
	parameter int MAX_COLS     = mcc_pkg::MaxCols,
	parameter int MAX_CHANNELS = mcc_pkg::MaxChannels,
	parameter int MAX_KERNEL   = mcc_pkg::MaxKernel
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [2:0]          k_eff,
	input  logic [2:0]          s_eff,
	input  logic [2:0]          pad,
	input  logic [10:0]         nr_eff,
	input  logic [10:0]         nc_eff,
	input  logic [4:0]          nch_eff,
	input  logic                job_valid,
	input  mcc_pkg::job_t       job,
	output logic                job_take,
	output logic                empty,
	input  logic                pop,
	output logic signed [mcc_pkg::SumW-1:0] sum_out,
	output logic                valid_position
);
	localparam int WD  = MAX_CHANNELS*MAX_KERNEL*MAX_KERNEL;
	localparam int PD  = MAX_CHANNELS*MAX_ROWS*MAX_COLS;
	localparam int WAW = $clog2(WD);
	localparam int PAW = $clog2(PD);
	localparam int SW  = mcc_pkg::SumW;
	localparam int AW  = SW + 8;

	typedef enum logic [2:0] {S_IDLE, S_RUN, S_DRAIN, S_DONE} state_t;

	logic signed [15:0] wmem [WD];
	logic signed [15:0] pmem [PD];

	state_t         state_q;
	logic [4:0]     c_q;
	logic [3:0]     i_q, j_q;
	logic [5:0]     row_q, col_q;
	logic           tap_s1, tap_s2, last_s1, last_s2, last_s3;
	logic signed [15:0] w_s2, p_s2;
	logic signed [31:0] prod_s3;
	logic signed [AW-1:0] acc_q;
	logic signed [SW-1:0] res_q;
	logic           vp_q, full_q;
	logic signed [13:0] r, q;
	logic           in_img, last_tap, is_cmp;
	logic [WAW-1:0] wra;
	logic [PAW-1:0] pra;
	logic           wwe, pwe;
	logic [WAW-1:0] waddr;
	logic [PAW-1:0] paddr;

	// tap position and image bounds
	assign r = 14'(row_q) * 14'(s_eff) + 14'(i_q) - 14'(pad);
	assign q = 14'(col_q) * 14'(s_eff) + 14'(j_q) - 14'(pad);
	assign in_img = (r >= 0) && (r < $signed({3'd0, nr_eff}))
		&& (q >= 0) && (q < $signed({3'd0, nc_eff}));
	assign last_tap = (j_q == 4'(k_eff - 1)) && (i_q == 4'(k_eff - 1))
		&& (c_q == nch_eff - 5'd1);
	assign wra = WAW'((32'(c_q) * MAX_KERNEL + 32'(i_q)) * MAX_KERNEL + 32'(j_q));
	assign pra = PAW'((32'(c_q) * MAX_ROWS + 32'(r[12:0])) * MAX_COLS + 32'(q[12:0]));

	// a write leaves the queue whenever the back end is idle; a compute job also waits for the result slot
	assign is_cmp   = (job.act == mcc_pkg::ACT_COMPUTE);
	assign job_take = (state_q == S_IDLE) && job_valid && (!is_cmp || !full_q);
	assign wwe      = job_take && (job.act == mcc_pkg::ACT_WEIGHT);
	assign pwe      = job_take && (job.act == mcc_pkg::ACT_PIXEL);
	assign waddr    = WAW'((32'(job.channel) * MAX_KERNEL + 32'(job.row_pos)) * MAX_KERNEL
		+ 32'(job.col_pos));
	assign paddr    = PAW'((32'(job.channel) * MAX_ROWS + 32'(job.row_pos)) * MAX_COLS
		+ 32'(job.col_pos));

	assign empty    = !full_q;
	assign sum_out  = res_q;
	assign valid_position = vp_q;

	// store writes and registered reads
	always_ff @(posedge clk) begin
		if (wwe) wmem[waddr] <= job.data;
		if (pwe) pmem[paddr] <= job.data;
		w_s2 <= wmem[wra];
		p_s2 <= pmem[pra];
		prod_s3 <= w_s2 * p_s2;
	end

	// sequencer, tap pipeline valids and accumulator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			c_q <= '0; i_q <= '0; j_q <= '0;
			row_q <= '0; col_q <= '0;
			tap_s1 <= 1'b0; tap_s2 <= 1'b0;
			last_s1 <= 1'b0; last_s2 <= 1'b0; last_s3 <= 1'b0;
			acc_q <= '0; res_q <= '0; vp_q <= 1'b0; full_q <= 1'b0;
		end else begin
			tap_s1  <= 1'b0;
			last_s1 <= 1'b0;
			tap_s2  <= tap_s1;  last_s2 <= last_s1;
			last_s3 <= last_s2;
			if (pop && full_q) full_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (job_valid && is_cmp && !full_q) begin
						if (job.in_range) begin
							row_q <= job.row_pos; col_q <= job.col_pos;
							c_q <= '0; i_q <= '0; j_q <= '0;
							acc_q <= '0;
							state_q <= S_RUN;
						end else begin
							res_q <= '0; vp_q <= 1'b0; full_q <= 1'b1;
						end
					end
				end
				S_RUN: begin
					tap_s1  <= in_img;
					last_s1 <= last_tap;
					if (last_tap) begin
						state_q <= S_DRAIN;
					end else if (j_q == 4'(k_eff - 1)) begin
						j_q <= '0;
						if (i_q == 4'(k_eff - 1)) begin
							i_q <= '0; c_q <= c_q + 5'd1;
						end else begin
							i_q <= i_q + 4'd1;
						end
					end else begin
						j_q <= j_q + 4'd1;
					end
				end
				S_DRAIN: begin
					if (last_s3) state_q <= S_DONE;
				end
				S_DONE: begin
					res_q <= SW'(acc_q); vp_q <= 1'b1; full_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
			// the product register lines up with the second tap valid
			if (tap_s2) acc_q <= acc_q + AW'(prod_s3);
		end
	end
endmodule

### rtl/multichannel_conv2d_point.sv
// Multichannel 2-D cross-correlation at one output point, stride and zero border.
// Top level: configuration registers, front end and back end.
// Depends on mcc_pkg, mcc_front, mcc_back.
//
// Input channel is a queue write side: an item is taken when push is high and
// full is low. Actions 0 and 1 write a weight or a pixel into its store and give
// no result. Action 2 queues a compute job; action 3 is dropped.
// Results come out as a queue read side: while empty is low, sum_out and
// valid_position hold the oldest result; pop takes it.
// With the back end free, a compute job passes through the job queue and a start
// step, then runs one tap per cycle through the single multiplier, then through
// store read, multiply and accumulate, and last the result is posted. A position
// beyond the output size posts valid_position low and sum 0 without walking any
// taps. Each store write is done in the back end as it leaves the queue.
// A two-entry queue holds writes and jobs in order; writes drain while a result
// waits, a compute job waits until the result is popped, and full rises when
// the queue fills.
// Reset clears the registers to their defaults and empties all queues;
// the stores are undefined until written and need no clearing.
// The user must write registers over cfg_we/cfg_index/cfg_data only while idle; the block does not enforce it.
module multichannel_conv2d_point #(
	parameter int MAX_ROWS     = mcc_pkg::MaxRows,
	parameter int MAX_COLS     = mcc_pkg::MaxCols,
	parameter int MAX_CHANNELS = mcc_pkg::MaxChannels,
	parameter int MAX_KERNEL   = mcc_pkg::MaxKernel
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  logic [1:0]          action,
	input  logic [1:0]          channel,
	input  logic [5:0]          row_pos,
	input  logic [5:0]          col_pos,
	input  logic signed [15:0]  weight,
	input  logic signed [15:0]  pixel,
	output logic                empty,
	input  logic                pop,
	output logic signed [mcc_pkg::SumW-1:0] sum_out,
	output logic                valid_position,
	input  logic                cfg_we,
	input  logic [mcc_pkg::IdxW-1:0] cfg_index,
	input  logic [mcc_pkg::CfgW-1:0] cfg_data
);
	localparam int KT  = (MAX_KERNEL < 7) ? MAX_KERNEL : 7;
	localparam int RT  = (MAX_ROWS < 64) ? MAX_ROWS : 64;
	localparam int CT  = (MAX_COLS < 64) ? MAX_COLS : 64;
	localparam int HT  = (MAX_CHANNELS < 4) ? MAX_CHANNELS : 4;

	logic [2:0]  ks_q, st_q, pad_q, ch_q;
	logic [6:0]  nr_q, nc_q;
	logic [2:0]  k_eff, s_eff;
	logic [10:0] nr_eff, nc_eff;
	logic [4:0]  nch_eff;

	logic               job_valid, job_take;
	mcc_pkg::job_t      job;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ks_q <= 3'd3; st_q <= 3'd1; pad_q <= 3'd0;
			nr_q <= 7'd64; nc_q <= 7'd64; ch_q <= 3'd3;
		end else if (cfg_we) begin
			case (cfg_index)
				mcc_pkg::REG_KERNEL:  ks_q  <= cfg_data[2:0];
				mcc_pkg::REG_STRIDE:  st_q  <= cfg_data[2:0];
				mcc_pkg::REG_PAD:     pad_q <= cfg_data[2:0];
				mcc_pkg::REG_ROWS:    nr_q  <= cfg_data;
				mcc_pkg::REG_COLS:    nc_q  <= cfg_data;
				mcc_pkg::REG_CHANNEL: ch_q  <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	// saturate register values into their usable range
	assign k_eff   = (ks_q == 0) ? 3'd1 : (32'(ks_q) > KT) ? 3'(KT) : ks_q;
	assign s_eff   = (st_q == 0) ? 3'd1 : st_q;
	assign nr_eff  = (nr_q == 0) ? 11'd1 : (32'(nr_q) > RT) ? 11'(RT) : 11'(nr_q);
	assign nc_eff  = (nc_q == 0) ? 11'd1 : (32'(nc_q) > CT) ? 11'(CT) : 11'(nc_q);
	assign nch_eff = (ch_q == 0) ? 5'd1 : (32'(ch_q) > HT) ? 5'(HT) : 5'(ch_q);

	mcc_front #(
		.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS),
		.MAX_CHANNELS(MAX_CHANNELS), .MAX_KERNEL(MAX_KERNEL)
	) u_front (
		.clk, .arst_n, .push, .full, .action, .channel, .row_pos, .col_pos,
		.weight, .pixel, .k_eff, .s_eff, .pad(pad_q), .nr_eff, .nc_eff,
		.job_valid, .job, .job_take
	);

	mcc_back #(
		.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS),
		.MAX_CHANNELS(MAX_CHANNELS), .MAX_KERNEL(MAX_KERNEL)
	) u_back (
		.clk, .arst_n, .k_eff, .s_eff, .pad(pad_q), .nr_eff, .nc_eff, .nch_eff,
		.job_valid, .job, .job_take,
		.empty, .pop, .sum_out, .valid_position
	);
endmodule

### rtl/mcc_checker.sv
// Port-level checker for the point convolution block, bound to the top level.
// Depends on mcc_pkg only for widths.
module mcc_checker (
	input logic clk,
	input logic arst_n,
	input logic full,
	input logic empty,
	input logic pop,
	input logic signed [mcc_pkg::SumW-1:0] sum_out,
	input logic valid_position
);
	// a waiting result holds until it is taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(sum_out) && $stable(valid_position)))
		else $error("result changed while waiting");

	// an out-of-range position always carries a zero sum
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !valid_position) |-> (sum_out == '0))
		else $error("invalid position with nonzero sum");

	// nothing waits right after reset
	a_rst: assert property (@(posedge clk) $rose(arst_n) |-> empty && !full)
		else $error("not empty after reset");
endmodule

bind multichannel_conv2d_point mcc_checker u_chk (
	.clk, .arst_n, .full, .empty, .pop, .sum_out, .valid_position
);

### tb/multichannel_conv2d_point_tb.sv
// Self-checking testbench for multichannel_conv2d_point: per-channel stores, register phases.
// Predicts each point sum in-bench and compares every popped result in order.
// Depends on mcc_pkg and the multichannel_conv2d_point RTL.
`timescale 1ns / 1ps

module multichannel_conv2d_point_tb;

	localparam logic [1:0] ACT_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 3000000;
	localparam int DRAIN_CYCLES = 300;
	localparam int PHASE_ITEMS = 125;
	localparam int SUM_W = mcc_pkg::SumW;
	localparam int IDX_W = mcc_pkg::IdxW;
	localparam int CFG_W = mcc_pkg::CfgW;
	localparam int N_CH = mcc_pkg::MaxChannels;
	localparam int N_K = mcc_pkg::MaxKernel;
	localparam int N_R = mcc_pkg::MaxRows;
	localparam int N_C = mcc_pkg::MaxCols;

	typedef struct packed {
		logic [1:0]         act;
		logic [1:0]         ch;
		logic [5:0]         row;
		logic [5:0]         col;
		logic signed [15:0] wgt;
		logic signed [15:0] pix;
	} conv_item_t;

	typedef struct packed {
		logic signed [SUM_W-1:0] sum;
		logic                    valid;
	} point_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b1;
	logic push = 1'b0;
	logic pop = 1'b0;
	logic full, empty, valid_position;
	logic [1:0] action = '0;
	logic [1:0] channel = '0;
	logic [5:0] row_pos = '0;
	logic [5:0] col_pos = '0;
	logic signed [15:0] weight = '0;
	logic signed [15:0] pixel = '0;
	logic signed [SUM_W-1:0] sum_out;
	logic cfg_we = 1'b0;
	logic [IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;

	// predictor state: the stores follow accepted transfers, the registers follow register writes
	logic signed [15:0] kern_mem [N_CH][N_K][N_K];
	logic signed [15:0] img_mem [N_CH][N_R][N_C];
	int unsigned reg_kernel = 3, reg_stride = 1, reg_pad = 0;
	int unsigned reg_rows = 64, reg_cols = 64, reg_chan = 3;

	// stimulus-side record of which store entries hold data
	bit kern_loaded [N_CH][N_K][N_K];
	bit img_loaded [N_CH][N_R][N_C];

	conv_item_t pending_items[$];
	conv_item_t cur_item;
	point_result_t expected_points[$];
	int send_idle = 31, recv_idle = 75;
	int mismatches = 0;
	int cycles = 0;
	int queued_count = 0;

	multichannel_conv2d_point u_dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.action(action), .channel(channel), .row_pos(row_pos), .col_pos(col_pos),
		.weight(weight), .pixel(pixel), .empty(empty), .pop(pop),
		.sum_out(sum_out), .valid_position(valid_position),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	function automatic int unsigned clamp(int unsigned v, int unsigned hi);
		if (v < 1) return 1;
		if (v > hi) return hi;
		return v;
	endfunction

	function automatic int unsigned out_extent(int unsigned img, int unsigned k,
			int unsigned pad, int unsigned s);
		int unsigned span;
		span = img + 2 * pad;
		if (span < k) return 0;
		return (span - k) / s + 1;
	endfunction

	// compute the expected point result under the current registers
	function automatic point_result_t predict_point(int unsigned rp, int unsigned cp);
		int unsigned k, s, pad, nr, nc, nch;
		longint acc;
		int r, q;
		point_result_t res;
		k = clamp(reg_kernel, N_K);
		s = clamp(reg_stride, 7);
		pad = reg_pad;
		nr = clamp(reg_rows, N_R);
		nc = clamp(reg_cols, N_C);
		nch = clamp(reg_chan, N_CH);
		acc = 0;
		res = '0;
		if (rp >= out_extent(nr, k, pad, s) || cp >= out_extent(nc, k, pad, s))
			return res;
		for (int c = 0; c < nch; c++)
			for (int i = 0; i < k; i++)
				for (int j = 0; j < k; j++) begin
					r = int'(rp * s + i) - int'(pad);
					q = int'(cp * s + j) - int'(pad);
					if (r >= 0 && r < nr && q >= 0 && q < nc)
						acc += longint'(kern_mem[c][i][j]) * longint'(img_mem[c][r][q]);
				end
		if (acc > 64'sd549755813887) acc = 64'sd549755813887;
		if (acc < -64'sd549755813888) acc = -64'sd549755813888;
		res.sum = acc[SUM_W-1:0];
		res.valid = 1'b1;
		return res;
	endfunction

	// apply one accepted transfer to the predictor
	task automatic absorb_item(conv_item_t it);
		case (it.act)
			mcc_pkg::ACT_WEIGHT: begin
				if (it.row < N_K && it.col < N_K)
					kern_mem[it.ch][it.row][it.col] = it.wgt;
			end
			mcc_pkg::ACT_PIXEL: img_mem[it.ch][it.row][it.col] = it.pix;
			mcc_pkg::ACT_COMPUTE: expected_points.push_back(predict_point(it.row, it.col));
			default: ;
		endcase
	endtask

	// driver: hold the item until transfer, then advance
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push <= 1'b0;
		end else begin
			automatic bit busy = push && full;
			if (push && !full)
				absorb_item(cur_item);
			if (!busy) begin
				if (pending_items.size() > 0 && $urandom_range(99) >= send_idle) begin
					cur_item = pending_items.pop_front();
					push <= 1'b1;
					action <= cur_item.act;
					channel <= cur_item.ch;
					row_pos <= cur_item.row;
					col_pos <= cur_item.col;
					weight <= cur_item.wgt;
					pixel <= cur_item.pix;
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	// monitor: check each popped result against the oldest expectation
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				if (expected_points.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result: sum %0d valid %0b", sum_out, valid_position);
				end else begin
					automatic point_result_t exp_pt = expected_points.pop_front();
					if (exp_pt.sum !== sum_out || exp_pt.valid !== valid_position) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected sum %0d valid %0b, got sum %0d valid %0b",
								exp_pt.sum, exp_pt.valid, sum_out, valid_position);
					end
				end
			end
			pop <= ($urandom_range(99) >= recv_idle);
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("multichannel_conv2d_point regression: fail");
			$finish;
		end
	end

	function automatic logic signed [15:0] rand_value();
		case ($urandom_range(7))
			0: return 16'sh7fff;
			1: return 16'sh8000;
			default: return 16'($urandom());
		endcase
	endfunction

	task automatic queue_item(logic [1:0] act, int ch, int r, int c,
			logic signed [15:0] w, logic signed [15:0] p);
		conv_item_t it;
		it.act = act;
		it.ch = 2'(ch);
		it.row = 6'(r);
		it.col = 6'(c);
		it.wgt = w;
		it.pix = p;
		if (act == mcc_pkg::ACT_WEIGHT && r < N_K && c < N_K)
			kern_loaded[ch][r][c] = 1'b1;
		if (act == mcc_pkg::ACT_PIXEL)
			img_loaded[ch][r][c] = 1'b1;
		pending_items.push_back(it);
		queued_count++;
	endtask

	// queue a point request, loading first any entry it reads that holds no data
	task automatic queue_point(int unsigned rp, int unsigned cp);
		int unsigned k, s, pad, nr, nc, nch;
		int r, q;
		k = clamp(reg_kernel, N_K);
		s = clamp(reg_stride, 7);
		pad = reg_pad;
		nr = clamp(reg_rows, N_R);
		nc = clamp(reg_cols, N_C);
		nch = clamp(reg_chan, N_CH);
		if (rp < out_extent(nr, k, pad, s) && cp < out_extent(nc, k, pad, s))
			for (int c = 0; c < nch; c++)
				for (int i = 0; i < k; i++)
					for (int j = 0; j < k; j++) begin
						r = int'(rp * s + i) - int'(pad);
						q = int'(cp * s + j) - int'(pad);
						if (r >= 0 && r < nr && q >= 0 && q < nc) begin
							if (!kern_loaded[c][i][j])
								queue_item(mcc_pkg::ACT_WEIGHT, c, i, j, rand_value(), 16'sd0);
							if (!img_loaded[c][r][q])
								queue_item(mcc_pkg::ACT_PIXEL, c, r, q, 16'sd0, rand_value());
						end
					end
		queue_item(mcc_pkg::ACT_COMPUTE, $urandom_range(3), rp, cp,
			16'($urandom()), 16'($urandom()));
	endtask

	task automatic queue_random_point();
		int unsigned k, s, pad, orows, ocols, rp, cp;
		k = clamp(reg_kernel, N_K);
		s = clamp(reg_stride, 7);
		pad = reg_pad;
		orows = out_extent(clamp(reg_rows, N_R), k, pad, s);
		ocols = out_extent(clamp(reg_cols, N_C), k, pad, s);
		if (orows == 0 || orows > 63 || $urandom_range(7) != 0)
			rp = (orows == 0) ? $urandom_range(63) : $urandom_range(orows - 1);
		else
			rp = $urandom_range(63, orows);
		if (ocols == 0 || ocols > 63 || $urandom_range(7) != 0)
			cp = (ocols == 0) ? $urandom_range(63) : $urandom_range(ocols - 1);
		else
			cp = $urandom_range(63, ocols);
		queue_point(rp, cp);
	endtask

	task automatic wait_idle();
		while (!(pending_items.size() == 0 && !push && expected_points.size() == 0))
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [IDX_W-1:0] idx, int unsigned val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_W'(val);
		case (idx)
			mcc_pkg::REG_KERNEL: reg_kernel = val & 7;
			mcc_pkg::REG_STRIDE: reg_stride = val & 7;
			mcc_pkg::REG_PAD: reg_pad = val & 7;
			mcc_pkg::REG_ROWS: reg_rows = val & 127;
			mcc_pkg::REG_COLS: reg_cols = val & 127;
			mcc_pkg::REG_CHANNEL: reg_chan = val & 7;
			default: ;
		endcase
	endtask

	int unsigned phase_regs [8][6] = '{
		'{3, 1, 0, 64, 64, 3},
		'{7, 7, 6, 64, 64, 4},
		'{1, 1, 0, 1, 1, 1},
		'{0, 0, 7, 0, 127, 0},
		'{5, 2, 3, 10, 17, 2},
		'{7, 3, 7, 5, 5, 4},
		'{2, 7, 1, 64, 33, 7},
		'{3, 1, 2, 20, 20, 3}
	};

	initial begin
		arst_n <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// directed: store extremes, ignored writes, unused action, edge points
		queue_item(mcc_pkg::ACT_WEIGHT, 0, 0, 0, 16'sh7fff, 16'sd0);
		queue_item(mcc_pkg::ACT_PIXEL, 0, 0, 0, 16'sd0, 16'sh8000);
		queue_item(mcc_pkg::ACT_WEIGHT, 3, 7, 0, 16'sh1234, 16'sd0);
		queue_item(mcc_pkg::ACT_WEIGHT, 2, 0, 63, 16'sh4321, 16'sd0);
		queue_item(mcc_pkg::ACT_PIXEL, 3, 63, 63, 16'sd0, 16'sh7fff);
		queue_item(ACT_UNUSED, 3, 63, 63, 16'shffff, 16'shffff);
		queue_point(0, 0);
		queue_point(61, 61);
		queue_point(62, 0);
		queue_point(0, 62);
		queue_point(63, 63);
		queue_point(30, 17);

		for (int ph = 0; ph < 8; ph++) begin
			if (ph > 0) begin
				// registers change only with the block drained
				wait_idle();
				for (int r = 0; r < 6; r++)
					write_reg(IDX_W'(r), phase_regs[ph][r]);
				@(posedge clk);
				cfg_we <= 1'b0;
			end
			if (ph < 3) begin
				send_idle = 31;
				recv_idle = 75;
			end else if (ph < 6) begin
				send_idle = 75;
				recv_idle = 31;
			end else begin
				send_idle = 0;
				recv_idle = 0;
			end
			// store loads count toward the budget of each phase
			while (queued_count < (ph + 1) * PHASE_ITEMS) begin
				case ($urandom_range(9))
					0: queue_item(mcc_pkg::ACT_WEIGHT, $urandom_range(3), $urandom_range(63),
						$urandom_range(63), rand_value(), 16'($urandom()));
					1: queue_item(mcc_pkg::ACT_PIXEL, $urandom_range(3), $urandom_range(63),
						$urandom_range(63), 16'($urandom()), rand_value());
					2: queue_item(ACT_UNUSED, $urandom_range(3), $urandom_range(63),
						$urandom_range(63), 16'($urandom()), 16'($urandom()));
					default: queue_random_point();
				endcase
			end
		end

		wait_idle();
		if (mismatches == 0)
			$display("multichannel_conv2d_point regression: pass");
		else
			$display("multichannel_conv2d_point regression: fail");
		$finish;
	end

endmodule

### filelist.f
rtl/mcc_pkg.sv
rtl/mcc_front.sv
rtl/mcc_back.sv
rtl/multichannel_conv2d_point.sv
rtl/mcc_checker.sv
tb/multichannel_conv2d_point_tb.sv
